FILE: design/arc_swept_volume_collision_check_top_macros.svh
// Assertion macros of the checker file of the collision check block
`ifndef ARC_SWEPT_VOLUME_COLLISION_CHECK_TOP_MACROS_SVH
`define ARC_SWEPT_VOLUME_COLLISION_CHECK_TOP_MACROS_SVH

// Same-cycle implication, sampled on aclk, quiet while reset is held
`define ASCC_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on aclk, quiet while reset is held
`define ASCC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: design/ascc_pkg.sv
// Shared types, widths, constants and helpers of the collision check block
package ascc_pkg;

    // Port widths
    localparam int S_TDATA_W  = 128;
    localparam int S_TUSER_W  = 1;
    localparam int M_TDATA_W  = 64;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 31;

    // Working widths
    localparam int SW = 36;
    typedef logic signed [SW-1:0] sval_t;
    localparam int CW = 40;
    typedef logic signed [CW-1:0] cvec_t;
    typedef logic signed [33:0] ang_t;

    // Iteration counts of the shared units
    localparam int CORDIC_STEPS = 24;
    localparam int CORDIC_CNT_W = $clog2(CORDIC_STEPS);
    localparam int SQRT_STEPS   = 32;
    localparam int SQRT_CNT_W   = $clog2(SQRT_STEPS);
    localparam int DIV_W        = 45;
    localparam int DIV_CNT_W    = $clog2(DIV_W);
    localparam logic [DIV_W-1:0] DIV_NUM = {1'b1, {(DIV_W-1){1'b0}}};

    // Operation codes
    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_POINT = 1'b1;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_CAR_LENGTH      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CAR_WIDTH       = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_AXLE_SPACING    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SAFETY_MARGIN   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_START_CLEARANCE = 3'd4;

    // Geometry constants
    localparam logic [31:0]      STRAIGHT_LIMIT = 32'd2685;
    localparam logic [DIV_W-1:0] RADIUS_MAX     = 45'd1073741824;
    localparam logic [30:0]      VAL31_MAX      = 31'h7FFF_FFFF;
    localparam ang_t ANG_PI      = 34'sd843314857;
    localparam ang_t ANG_HALF_PI = 34'sd421657428;
    localparam ang_t ANG_TWO_PI  = 34'sd1686629713;

    localparam ang_t ATAN_HEAD [10] = '{
        34'sd210828714, 34'sd124459457, 34'sd65760959, 34'sd33381290, 34'sd16755422,
        34'sd8385879, 34'sd4193963, 34'sd2097109, 34'sd1048571, 34'sd524287
    };

    // Rotation angle of CORDIC step i in signed Q5.28 radians
    function automatic ang_t atan_step(input logic [5:0] i);
        ang_t r;
        if (i < 6'd10) begin
            r = ATAN_HEAD[i[3:0]];
        end else if (i <= 6'd28) begin
            r = ang_t'(1) << (6'd28 - i);
        end else begin
            r = '0;
        end
        return r;
    endfunction

    // Magnitude of a signed working value
    function automatic logic [SW-1:0] smag(input sval_t v);
        logic [SW-1:0] r;
        r = v[SW-1] ? unsigned'(-v) : unsigned'(v);
        return r;
    endfunction

    // Smaller of two magnitudes
    function automatic logic [SW-1:0] umin(input logic [SW-1:0] a, input logic [SW-1:0] b);
        logic [SW-1:0] r;
        r = (a < b) ? a : b;
        return r;
    endfunction

endpackage

FILE: design/arc_swept_volume_collision_check_top.sv
// Top level of the arc swept-volume collision check: sequencer, state and shared multiplier
//
//  Channel | Direction | Handshake            | Contents
//  s_      | in        | s_tvalid / s_tready  | tuser: operation; tdata: curvature, arc, x, y
//  m_      | out       | m_tvalid / m_tready  | tdata: free arc, clearance, hit flag
//  cfg_    | in        | cfg_valid / cfg_ready| cfg_index, cfg_data
//
//  A curved load runs the 45-step divider and three 32-step square roots;
//  a curved point runs at most two square roots and two CORDIC runs.
//  One item is in work at a time; s_tready is high only while idle.
//  A held result keeps the next item in its final state, so s_tready stays low until the
//  output register frees; reset is synchronous, aresetn low.
module arc_swept_volume_collision_check_top (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // [31:0] arc_curvature, [62:32] initial_arc_length, [94:63] point_x,
    // [126:95] point_y, [127] zero
    input  logic [ascc_pkg::S_TDATA_W-1:0]    s_tdata,
    // [0] operation
    input  logic [ascc_pkg::S_TUSER_W-1:0]    s_tuser,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // [30:0] free_arc_length, [61:31] path_clearance, [62] hit_seen, [63] zero
    output logic [ascc_pkg::M_TDATA_W-1:0]    m_tdata,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [ascc_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [ascc_pkg::CFG_DATA_W-1:0]   cfg_data
);
    import ascc_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE, S_DIVGO, S_DIV, S_MFR, S_MRR, S_MBX, S_MBN, S_SQ0, S_SQ0W, S_SQ1W,
        S_SQ2W, S_STR, S_PX, S_PDY, S_PSQ, S_PRW, S_PSPLIT, S_PU, S_PCW, S_ANG0,
        S_ANG1, S_AMUL, S_AARC, S_DONE
    } state_t;

    typedef enum logic [1:0] {C_INNER, C_OUTER, C_FRONT} hit_case_t;

    state_t    state_reg;
    hit_case_t case_reg;

    // Configuration
    logic [23:0] car_length_reg, car_width_reg, axle_spacing_reg, safety_margin_reg;
    logic [30:0] start_clearance_reg;

    // Arc state
    logic        curv_neg_reg, straight_reg, stopped_reg, hit_reg;
    logic [31:0] curv_mag_reg;
    sval_t       radius_reg, front_reg, rear_reg, hw_reg, bmin_reg, bmax_reg;
    logic [31:0] fmin_reg, fmax_reg, rmax_reg;
    logic [30:0] arc_reg, clr_reg;

    // Working registers
    sval_t       x_reg, y_reg, dy_reg, cx_reg, cyr_reg;
    logic [63:0] prod_reg, t0_reg, t1_reg, t2_reg, sq_reg;
    logic [31:0] rp_reg;
    ang_t        ang_reg, d_reg;

    // Output register
    logic        m_tvalid_reg;
    logic [62:0] m_data_reg;

    // Shared units
    logic              div_start, div_done, sqrt_start, sqrt_done, cord_start, cord_done;
    logic [DIV_W-1:0]  div_quot;
    logic [63:0]       sqrt_in;
    logic [31:0]       sqrt_root;
    cvec_t             cord_x, cord_y;
    ang_t              cord_ang;
    logic [32:0]       mul_a, mul_b;
    logic [65:0]       mul_full;

    // Comb helpers
    sval_t       len_s, wid_s, front_s, rear_s, hw_s, curv_s;
    logic [31:0] curv_mag_in;
    logic        straight_in;
    logic [30:0] q_sat;
    sval_t       q_s;
    sval_t       arc_s, str_a, str_a_clip, rp_s, fmin_s, fmax_s, rmax_s, root_s;
    logic [SW-1:0] c_str, c_ring, c_rmax, clr_u;
    logic        str_side, str_miss;
    logic        split_out, split_in, split_outer, split_front, under_u;
    ang_t        d_raw, d_wrap;
    logic [35:0] arc_raw;
    logic [30:0] arc_sat;

    // Load geometry and curvature from the incoming transfer
    always_comb begin
        len_s   = sval_t'({12'b0, car_length_reg}) + sval_t'({11'b0, safety_margin_reg, 1'b0});
        wid_s   = sval_t'({12'b0, car_width_reg}) + sval_t'({11'b0, safety_margin_reg, 1'b0});
        front_s = (len_s + sval_t'({12'b0, axle_spacing_reg})) >>> 1;
        rear_s  = len_s - front_s;
        hw_s    = wid_s >>> 1;
        curv_s  = sval_t'($signed(s_tdata[31:0]));
        curv_mag_in = s_tdata[31] ? 32'(~s_tdata[31:0] + 32'd1) : s_tdata[31:0];
        straight_in = curv_mag_in < STRAIGHT_LIMIT;
        q_sat   = (div_quot > RADIUS_MAX) ? RADIUS_MAX[30:0] : div_quot[30:0];
        q_s     = sval_t'({5'b0, q_sat});
    end

    // Straight box test and curved ring split
    always_comb begin
        arc_s      = sval_t'({5'b0, arc_reg});
        clr_u      = {5'b0, clr_reg};
        str_side   = (y_reg < -hw_reg) || (y_reg > hw_reg);
        c_str      = umin(smag(y_reg + hw_reg), smag(y_reg - hw_reg));
        str_miss   = (x_reg > arc_s + front_reg) || (x_reg < -rear_reg);
        str_a      = x_reg - front_reg;
        str_a_clip = str_a[SW-1] ? sval_t'(0) : str_a;
        rp_s       = sval_t'({4'b0, rp_reg});
        fmin_s     = sval_t'({4'b0, fmin_reg});
        fmax_s     = sval_t'({4'b0, fmax_reg});
        rmax_s     = sval_t'({4'b0, rmax_reg});
        root_s     = sval_t'({4'b0, sqrt_root});
        split_out  = (rp_s < bmin_reg) || (rp_s > fmax_s);
        split_in   = rp_s < fmin_s;
        split_outer = (rp_s > bmax_reg) && (rp_s < rmax_s)
                      && ($signed(smag(x_reg)) < rear_reg);
        split_front = (rp_s < fmax_s) && (x_reg > front_reg);
        c_ring     = umin(smag(rp_s - bmin_reg), smag(rp_s - fmax_s));
        c_rmax     = smag(rmax_s - rp_s);
        under_u    = sq_reg < prod_reg;
        d_raw      = ang_reg - cord_ang;
        if (d_raw > ANG_PI) begin
            d_wrap = d_raw - ANG_TWO_PI;
        end else if (d_raw < -ANG_PI) begin
            d_wrap = d_raw + ANG_TWO_PI;
        end else begin
            d_wrap = d_raw;
        end
        arc_raw = prod_reg[63:28];
        arc_sat = (arc_raw > {5'b0, VAL31_MAX}) ? VAL31_MAX : arc_raw[30:0];
    end

    // Shared multiplier operands
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        unique case (state_reg)
            S_MFR:  mul_a = 33'(smag(front_reg));
            S_MRR:  mul_a = 33'(smag(rear_reg));
            S_MBX:  mul_a = 33'(smag(bmax_reg));
            S_MBN:  mul_a = 33'(smag(bmin_reg));
            S_PX:   mul_a = 33'(smag(x_reg));
            S_PDY:  mul_a = 33'(smag(dy_reg));
            S_PSPLIT: begin
                priority if (split_in) begin
                    mul_a = 33'(smag(bmin_reg));
                end else if (split_outer) begin
                    mul_a = 33'(smag(bmax_reg));
                end else begin
                    mul_a = 33'(smag(front_reg));
                end
            end
            S_AMUL: mul_a = 33'(smag(radius_reg));
            default: mul_a = '0;
        endcase
        mul_b = (state_reg == S_AMUL) ? 33'(d_reg[33] ? -d_reg : d_reg) : mul_a;
        mul_full = mul_a * mul_b;
    end

    // Shared unit starts and operands
    always_comb begin
        div_start  = state_reg == S_DIVGO;
        sqrt_start = 1'b0;
        sqrt_in    = '0;
        unique case (state_reg)
            S_SQ0: begin
                sqrt_start = 1'b1;
                sqrt_in    = prod_reg + t0_reg;
            end
            S_SQ0W: begin
                sqrt_start = sqrt_done;
                sqrt_in    = t2_reg + t0_reg;
            end
            S_SQ1W: begin
                sqrt_start = sqrt_done;
                sqrt_in    = t2_reg + t1_reg;
            end
            S_PSQ: begin
                sqrt_start = 1'b1;
                sqrt_in    = prod_reg + t0_reg;
            end
            S_PU: begin
                sqrt_start = !under_u;
                sqrt_in    = sq_reg - prod_reg;
            end
            default: sqrt_start = 1'b0;
        endcase
        cord_start = ((state_reg == S_PCW) && sqrt_done) || ((state_reg == S_ANG0) && cord_done);
        cord_x     = (state_reg == S_ANG0) ? cvec_t'(cx_reg) : cvec_t'(x_reg);
        cord_y     = (state_reg == S_ANG0) ? cvec_t'(cyr_reg) : cvec_t'(dy_reg);
    end

    ascc_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .divisor  (curv_mag_reg),
        .done     (div_done),
        .quotient (div_quot)
    );

    ascc_sqrt u_sqrt (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (sqrt_start),
        .radicand (sqrt_in),
        .done     (sqrt_done),
        .root     (sqrt_root)
    );

    ascc_cordic u_cordic (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (cord_start),
        .x_in    (cord_x),
        .y_in    (cord_y),
        .done    (cord_done),
        .angle   (cord_ang)
    );

    // Sequencer, arc state and output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg           <= S_IDLE;
            m_tvalid_reg        <= 1'b0;
            car_length_reg      <= '0;
            car_width_reg       <= '0;
            axle_spacing_reg    <= '0;
            safety_margin_reg   <= '0;
            start_clearance_reg <= '0;
            curv_neg_reg        <= 1'b0;
            curv_mag_reg        <= '0;
            straight_reg        <= 1'b0;
            stopped_reg         <= 1'b0;
            hit_reg             <= 1'b0;
            radius_reg          <= '0;
            front_reg           <= '0;
            rear_reg            <= '0;
            hw_reg              <= '0;
            bmin_reg            <= '0;
            bmax_reg            <= '0;
            fmin_reg            <= '0;
            fmax_reg            <= '0;
            rmax_reg            <= '0;
            arc_reg             <= '0;
            clr_reg             <= '0;
        end else begin
            prod_reg <= mul_full[63:0];

            // Load a finished result, or drop the held one once transferred
            if (state_reg == S_DONE && (!m_tvalid_reg || m_tready)) begin
                m_tvalid_reg <= 1'b1;
                m_data_reg   <= {hit_reg, clr_reg, arc_reg};
            end else if (m_tvalid_reg && m_tready) begin
                m_tvalid_reg <= 1'b0;
            end

            // Register writes
            if (cfg_valid && cfg_ready) begin
                unique case (cfg_index)
                    CFG_CAR_LENGTH:      car_length_reg      <= cfg_data[23:0];
                    CFG_CAR_WIDTH:       car_width_reg       <= cfg_data[23:0];
                    CFG_AXLE_SPACING:    axle_spacing_reg    <= cfg_data[23:0];
                    CFG_SAFETY_MARGIN:   safety_margin_reg   <= cfg_data[23:0];
                    CFG_START_CLEARANCE: start_clearance_reg <= cfg_data;
                    default: ;
                endcase
            end

            unique case (state_reg)
                S_IDLE: begin
                    if (s_tvalid) begin
                        if (s_tuser[0] == OP_LOAD) begin
                            curv_neg_reg <= curv_s[SW-1];
                            curv_mag_reg <= curv_mag_in;
                            straight_reg <= straight_in;
                            front_reg    <= front_s;
                            rear_reg     <= rear_s;
                            hw_reg       <= hw_s;
                            radius_reg   <= '0;
                            bmin_reg     <= '0;
                            bmax_reg     <= '0;
                            fmin_reg     <= '0;
                            fmax_reg     <= '0;
                            rmax_reg     <= '0;
                            arc_reg      <= s_tdata[62:32];
                            clr_reg      <= start_clearance_reg;
                            stopped_reg  <= 1'b0;
                            hit_reg      <= 1'b0;
                            state_reg    <= straight_in ? S_DONE : S_DIVGO;
                        end else begin
                            x_reg     <= sval_t'($signed(s_tdata[94:63]));
                            y_reg     <= sval_t'($signed(s_tdata[126:95]));
                            state_reg <= straight_reg ? S_STR : S_PX;
                        end
                    end
                end
                S_DIVGO: state_reg <= S_DIV;
                S_DIV: begin
                    if (div_done) begin
                        radius_reg <= curv_neg_reg ? -q_s : q_s;
                        bmin_reg   <= q_s - hw_reg;
                        bmax_reg   <= q_s + hw_reg;
                        state_reg  <= S_MFR;
                    end
                end
                // Squares of the reaches and base radii
                S_MFR: state_reg <= S_MRR;
                S_MRR: begin
                    t0_reg    <= prod_reg;
                    state_reg <= S_MBX;
                end
                S_MBX: begin
                    t1_reg    <= prod_reg;
                    state_reg <= S_MBN;
                end
                S_MBN: begin
                    t2_reg    <= prod_reg;
                    state_reg <= S_SQ0;
                end
                S_SQ0: state_reg <= S_SQ0W;
                S_SQ0W: begin
                    if (sqrt_done) begin
                        fmin_reg  <= sqrt_root;
                        state_reg <= S_SQ1W;
                    end
                end
                S_SQ1W: begin
                    if (sqrt_done) begin
                        fmax_reg  <= sqrt_root;
                        state_reg <= S_SQ2W;
                    end
                end
                S_SQ2W: begin
                    if (sqrt_done) begin
                        rmax_reg  <= sqrt_root;
                        state_reg <= S_DONE;
                    end
                end
                // Straight arc: box test, freeze after the first hit
                S_STR: begin
                    if (!stopped_reg) begin
                        if (str_side) begin
                            if (c_str < clr_u) begin
                                clr_reg <= c_str[30:0];
                            end
                        end else if (!str_miss) begin
                            if (str_a_clip < arc_s) begin
                                arc_reg <= str_a_clip[30:0];
                            end
                            clr_reg     <= '0;
                            hit_reg     <= 1'b1;
                            stopped_reg <= 1'b1;
                        end
                    end
                    state_reg <= S_DONE;
                end
                // Curved arc: radius of the point about the turn centre
                S_PX: begin
                    dy_reg    <= y_reg - radius_reg;
                    state_reg <= (x_reg < -rear_reg) ? S_DONE : S_PDY;
                end
                S_PDY: begin
                    t0_reg    <= prod_reg;
                    state_reg <= S_PSQ;
                end
                S_PSQ: begin
                    sq_reg    <= prod_reg + t0_reg;
                    state_reg <= S_PRW;
                end
                S_PRW: begin
                    if (sqrt_done) begin
                        rp_reg    <= sqrt_root;
                        state_reg <= S_PSPLIT;
                    end
                end
                S_PSPLIT: begin
                    priority if (split_out) begin
                        if (c_ring < clr_u) begin
                            clr_reg <= c_ring[30:0];
                        end
                        state_reg <= S_DONE;
                    end else if (split_in) begin
                        case_reg  <= C_INNER;
                        state_reg <= (rp_reg == '0) ? S_DONE : S_PU;
                    end else if (split_outer) begin
                        case_reg  <= C_OUTER;
                        state_reg <= (rp_reg == '0) ? S_DONE : S_PU;
                    end else if (split_front) begin
                        case_reg  <= C_FRONT;
                        state_reg <= (rp_reg == '0) ? S_DONE : S_PU;
                    end else begin
                        if (c_rmax < clr_u) begin
                            clr_reg <= c_rmax[30:0];
                        end
                        state_reg <= S_DONE;
                    end
                end
                S_PU: state_reg <= under_u ? S_DONE : S_PCW;
                // Collision point on the swept outline
                S_PCW: begin
                    if (sqrt_done) begin
                        unique case (case_reg)
                            C_INNER: begin
                                cx_reg  <= root_s;
                                cyr_reg <= curv_neg_reg ? bmin_reg : -bmin_reg;
                            end
                            C_OUTER: begin
                                cx_reg  <= root_s;
                                cyr_reg <= curv_neg_reg ? bmax_reg : -bmax_reg;
                            end
                            C_FRONT: begin
                                cx_reg  <= front_reg;
                                cyr_reg <= curv_neg_reg ? root_s : -root_s;
                            end
                            default: begin
                                cx_reg  <= root_s;
                                cyr_reg <= root_s;
                            end
                        endcase
                        state_reg <= S_ANG0;
                    end
                end
                S_ANG0: begin
                    if (cord_done) begin
                        ang_reg   <= cord_ang;
                        state_reg <= S_ANG1;
                    end
                end
                S_ANG1: begin
                    if (cord_done) begin
                        d_reg     <= d_wrap;
                        state_reg <= S_AMUL;
                    end
                end
                S_AMUL: state_reg <= S_AARC;
                S_AARC: begin
                    if (arc_sat < arc_reg) begin
                        arc_reg <= arc_sat;
                        clr_reg <= '0;
                        hit_reg <= 1'b1;
                    end
                    state_reg <= S_DONE;
                end
                // Hold until the output register takes the result
                S_DONE: begin
                    if (!m_tvalid_reg || m_tready) begin
                        state_reg <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign s_tready  = state_reg == S_IDLE;
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = {1'b0, m_data_reg};
    assign cfg_ready = 1'b1;

endmodule

FILE: design/ascc_sqrt.sv
// Bit-serial floored square root of a 64-bit value, two radicand bits per cycle
module ascc_sqrt (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        start,
    input  logic [63:0] radicand,
    output logic        done,
    output logic [31:0] root
);
    import ascc_pkg::*;

    logic                  busy_reg;
    logic                  done_reg;
    logic [SQRT_CNT_W-1:0] cnt_reg;
    logic [63:0]           rad_reg;
    logic [33:0]           rem_reg;
    logic [31:0]           root_reg;
    logic [35:0]           rem_sh;
    logic [35:0]           trial;
    logic                  take;

    // One digit of the root per step
    always_comb begin
        rem_sh = {rem_reg, rad_reg[63:62]};
        trial  = {2'b00, root_reg, 2'b01};
        take   = rem_sh >= trial;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
                rad_reg  <= radicand;
                rem_reg  <= '0;
                root_reg <= '0;
            end else if (busy_reg) begin
                rad_reg <= {rad_reg[61:0], 2'b00};
                if (take) begin
                    rem_reg  <= 34'(rem_sh - trial);
                    root_reg <= {root_reg[30:0], 1'b1};
                end else begin
                    rem_reg  <= rem_sh[33:0];
                    root_reg <= {root_reg[30:0], 1'b0};
                end
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == SQRT_CNT_W'(SQRT_STEPS - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign done = done_reg;
    assign root = root_reg;

endmodule

FILE: design/ascc_div.sv
// Restoring divider of the fixed radius numerator by the curvature magnitude
module ascc_div (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        start,
    input  logic [31:0]                 divisor,
    output logic                        done,
    output logic [ascc_pkg::DIV_W-1:0]  quotient
);
    import ascc_pkg::*;

    logic                 busy_reg;
    logic                 done_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic [DIV_W-1:0]     num_reg;
    logic [DIV_W-1:0]     quot_reg;
    logic [31:0]          den_reg;
    logic [31:0]          rem_reg;
    logic [32:0]          rem_sh;
    logic                 take;

    // Shift in one numerator bit and try the subtraction
    always_comb begin
        rem_sh = {rem_reg, num_reg[DIV_W-1]};
        take   = rem_sh >= {1'b0, den_reg};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
                num_reg  <= DIV_NUM;
                den_reg  <= divisor;
                rem_reg  <= '0;
                quot_reg <= '0;
            end else if (busy_reg) begin
                num_reg  <= {num_reg[DIV_W-2:0], 1'b0};
                rem_reg  <= take ? 32'(rem_sh - {1'b0, den_reg}) : rem_sh[31:0];
                quot_reg <= {quot_reg[DIV_W-2:0], take};
                cnt_reg  <= cnt_reg + 1'b1;
                if (cnt_reg == DIV_CNT_W'(DIV_W - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign done     = done_reg;
    assign quotient = quot_reg;

endmodule

FILE: design/ascc_cordic.sv
// Vectoring CORDIC: angle of a vector, one micro-rotation per cycle
module ascc_cordic (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  start,
    input  ascc_pkg::cvec_t       x_in,
    input  ascc_pkg::cvec_t       y_in,
    output logic                  done,
    output ascc_pkg::ang_t        angle
);
    import ascc_pkg::*;

    logic                    busy_reg;
    logic                    done_reg;
    logic [CORDIC_CNT_W-1:0] cnt_reg;
    cvec_t                   x_reg;
    cvec_t                   y_reg;
    ang_t                    z_reg;
    cvec_t                   dx;
    cvec_t                   dy;
    ang_t                    step_ang;

    always_comb begin
        dx       = y_reg >>> cnt_reg;
        dy       = x_reg >>> cnt_reg;
        step_ang = atan_step(6'(cnt_reg));
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
                // Fold the left half plane onto the right
                if (!x_in[CW-1]) begin
                    x_reg <= x_in;
                    y_reg <= y_in;
                    z_reg <= '0;
                end else if (!y_in[CW-1]) begin
                    x_reg <= y_in;
                    y_reg <= -x_in;
                    z_reg <= ANG_HALF_PI;
                end else begin
                    x_reg <= -y_in;
                    y_reg <= x_in;
                    z_reg <= -ANG_HALF_PI;
                end
            end else if (busy_reg) begin
                // Rotate towards the x axis
                if (y_reg > 0) begin
                    x_reg <= x_reg + dx;
                    y_reg <= y_reg - dy;
                    z_reg <= z_reg + step_ang;
                end else begin
                    x_reg <= x_reg - dx;
                    y_reg <= y_reg + dy;
                    z_reg <= z_reg - step_ang;
                end
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CORDIC_CNT_W'(CORDIC_STEPS - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign done  = done_reg;
    assign angle = z_reg;

endmodule

FILE: design/ascc_checker.sv
// Port-level checker of the collision check block and its bind
`include "arc_swept_volume_collision_check_top_macros.svh"

module ascc_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [63:0] m_tdata
);
    // One item at a time: no transfer in the cycle after one
    `ASCC_ASSERT_NEXT(a_one_item, s_tvalid && s_tready, !s_tready, "input taken while busy")

    // A stalled result stays and holds its data
    `ASCC_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "result changed while stalled")

    // A hit leaves no clearance
    `ASCC_ASSERT_NOW(a_hit_clear, m_tvalid && m_tdata[62], m_tdata[61:31] == 31'd0, "clearance left after hit")

endmodule

bind arc_swept_volume_collision_check_top ascc_checker u_checker (.*);
